FILE: sv/sgfr_pkg.sv
// ----------------------------------------------------------------------------
// sgfr_pkg
// Shared constants, types and glyph ROM for the scaled glyph renderer.
// ----------------------------------------------------------------------------
package sgfr_pkg;

  localparam int WIDTH      = 128;
  localparam int PAGES      = 8;
  localparam int STORE_SIZE = WIDTH * PAGES;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int HEIGHT     = PAGES * 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_NUM   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x;
    logic [2:0] page;
    logic [7:0] char_code;
    logic [3:0] scale;
    logic [31:0] number;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  // Glyph index lookup; returns valid flag in bit 5.
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [5:0] r;
    r = 6'd0;
    if (code >= 8'h30 && code <= 8'h39) r = {1'b1, 5'(code - 8'h30)};
    else begin
      case (code)
        8'h53: r = {1'b1, 5'd10};
        8'h43: r = {1'b1, 5'd11};
        8'h4F: r = {1'b1, 5'd12};
        8'h52: r = {1'b1, 5'd13};
        8'h45: r = {1'b1, 5'd14};
        8'h48: r = {1'b1, 5'd15};
        8'h49: r = {1'b1, 5'd16};
        8'h54: r = {1'b1, 5'd17};
        8'h4D: r = {1'b1, 5'd18};
        8'h50: r = {1'b1, 5'd19};
        8'h46: r = {1'b1, 5'd20};
        8'h21: r = {1'b1, 5'd21};
        default: r = 6'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [6:0] glyph_col(input logic [4:0] g, input logic [2:0] c);
    logic [39:0] row;
    case (g)
      5'd0:  row = 40'h7F_41_41_41_7F;
      5'd1:  row = 40'h00_42_7F_40_00;
      5'd2:  row = 40'h79_49_49_49_4F;
      5'd3:  row = 40'h49_49_49_49_7F;
      5'd4:  row = 40'h0F_08_08_08_7F;
      5'd5:  row = 40'h4F_49_49_49_79;
      5'd6:  row = 40'h7F_49_49_49_79;
      5'd7:  row = 40'h01_71_09_05_03;
      5'd8:  row = 40'h7F_49_49_49_7F;
      5'd9:  row = 40'h4F_49_49_49_7F;
      5'd10: row = 40'h07_49_49_49_70;
      5'd11: row = 40'h3E_41_41_41_41;
      5'd12: row = 40'h3E_41_41_41_3E;
      5'd13: row = 40'h7F_09_19_29_46;
      5'd14: row = 40'h7F_49_49_49_41;
      5'd15: row = 40'h7F_08_08_08_7F;
      5'd16: row = 40'h41_41_7F_41_41;
      5'd17: row = 40'h01_01_7F_01_01;
      5'd18: row = 40'h7F_02_04_02_7F;
      5'd19: row = 40'h7F_09_09_09_06;
      5'd20: row = 40'h7F_09_09_09_01;
      5'd21: row = 40'h00_00_5F_00_00;
      default: row = 40'h0;
    endcase
    case (c)
      3'd0: return row[38:32];
      3'd1: return row[30:24];
      3'd2: return row[22:16];
      3'd3: return row[14:8];
      3'd4: return row[6:0];
      default: return 7'd0;
    endcase
  endfunction

endpackage

FILE: sv/sgfr_if.sv
// ----------------------------------------------------------------------------
// sgfr_in_if / sgfr_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface sgfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  x;
  logic [2:0]  page;
  logic [7:0]  char_code;
  logic [3:0]  scale;
  logic [31:0] number;
  modport source (output valid, op, x, page, char_code, scale, number, input ready);
  modport sink   (input valid, op, x, page, char_code, scale, number, output ready);
endinterface

interface sgfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] next_x;
  modport source (output valid, read_data, next_x, input ready);
  modport sink   (input valid, read_data, next_x, output ready);
endinterface

FILE: sv/sgfr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sgfr_cmd_fifo
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module sgfr_cmd_fifo
  import sgfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

FILE: sv/sgfr_front.sv
// ----------------------------------------------------------------------------
// sgfr_front
// Accepts commands, normalizes scale and forwards them to the queue.
// ----------------------------------------------------------------------------
module sgfr_front
  import sgfr_pkg::*;
(
  sgfr_in_if.sink in_ch,
  output logic    q_valid,
  input  logic    q_ready,
  output cmd_t    q_data
);
  assign in_ch.ready      = q_ready;
  assign q_valid          = in_ch.valid;
  assign q_data.op        = in_ch.op;
  assign q_data.x         = in_ch.x;
  assign q_data.page      = in_ch.page;
  assign q_data.char_code = in_ch.char_code;
  assign q_data.scale     = (in_ch.scale == 4'd0) ? 4'd1 : in_ch.scale;
  assign q_data.number    = in_ch.number;
endmodule

FILE: sv/sgfr_back.sv
// ----------------------------------------------------------------------------
// sgfr_back
// Executes commands against the frame store; takes a new command only when idle.
// ----------------------------------------------------------------------------
module sgfr_back
  import sgfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_data,
  sgfr_out_if.source  out_ch
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_DIV, S_DIG, S_GLYPH, S_PIX, S_RMW_RD, S_RMW_WR,
    S_NEXT, S_RD, S_RD2, S_OUT
  } state_t;

  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        rdata_r;
  state_t            st_r;
  cmd_t              cmd_r;
  logic [ADDR_W:0]   clr_r;
  logic [31:0]       num_r;
  logic [3:0]        dig_r [10];
  logic [3:0]        nd_r, di_r;
  logic [31:0]       quo_r;
  logic [4:0]        g_r;
  logic [7:0]        cx_r;          // glyph origin x
  logic [2:0]        c_r, r_r;
  logic [3:0]        dx_r, dy_r;
  logic [7:0]        col_r, row_r;
  logic [7:0]        rd_r, nx_r;
  logic [7:0]        out_rd_r, out_nx_r;
  logic              ov_r;

  logic [7:0]        sc8;
  logic [63:0]       recip_prod;
  logic [31:0]       rem_full;
  logic [5:0]        gi;
  logic [6:0]        gcol;
  logic              set_pix;
  logic              pix_on;

  assign sc8        = {4'd0, cmd_r.scale};
  // divide by ten: multiply by ceil(2^35/10), keep bits 63:35
  assign recip_prod = {32'd0, num_r} * 64'h0000_0000_CCCC_CCCD;
  assign rem_full   = num_r - ({quo_r[28:0], 3'b000} + {quo_r[30:0], 1'b0});
  assign gi      = glyph_index(cmd_r.op == OP_NUM ? 8'h30 + {4'd0, dig_r[di_r]} : cmd_r.char_code);
  assign gcol    = glyph_col(g_r, c_r);
  assign set_pix = gcol[r_r];
  assign pix_on  = set_pix && col_r < 8'(WIDTH) && row_r < 8'(HEIGHT);

  logic [ADDR_W-1:0] pix_addr;
  assign pix_addr = ADDR_W'(32'(row_r[7:3]) * WIDTH + 32'(col_r));

  assign q_ready          = (st_r == S_IDLE);
  assign out_ch.valid     = ov_r;
  assign out_ch.read_data = out_rd_r;
  assign out_ch.next_x    = out_nx_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[pix_addr];
    if (st_r == S_CLR || st_r == S_INIT) mem[clr_r[ADDR_W-1:0]] <= 8'd0;
    if (st_r == S_RMW_WR && pix_on) mem[pix_addr] <= rdata_r | (8'd1 << row_r[2:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; clr_r <= '0; ov_r <= 1'b0;
      out_rd_r <= 8'd0; out_nx_r <= 8'd0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (st_r)
        S_INIT, S_CLR: begin
          clr_r <= clr_r + (ADDR_W+1)'(1);
          if (clr_r == (ADDR_W+1)'(STORE_SIZE - 1)) begin
            st_r <= (st_r == S_INIT) ? S_IDLE : S_OUT;
          end
        end
        S_IDLE: if (q_valid) begin
          cmd_r <= q_data; nx_r <= q_data.x; rd_r <= 8'd0;
          clr_r <= '0;
          num_r <= q_data.number; nd_r <= 4'd0; quo_r <= '0;
          di_r <= 4'd0;
          row_r <= {2'b0, q_data.page, 3'd0}; col_r <= q_data.x;
          unique case (q_data.op)
            OP_CLEAR: st_r <= S_CLR;
            OP_CHAR:  st_r <= S_GLYPH;
            OP_NUM:   st_r <= S_DIV;
            default:  st_r <= S_RD;
          endcase
        end
        S_DIV: begin
          quo_r <= {3'd0, recip_prod[63:35]};
          st_r  <= S_DIG;
        end
        S_DIG: begin
          // remainder is the digit, least significant first
          dig_r[nd_r] <= rem_full[3:0];
          nd_r <= nd_r + 4'd1;
          num_r <= quo_r;
          if (quo_r == 32'd0 || nd_r == 4'd9) begin
            di_r <= nd_r; st_r <= S_GLYPH;
          end else st_r <= S_DIV;
        end
        S_GLYPH: begin
          g_r <= gi[4:0]; cx_r <= nx_r;
          c_r <= 3'd0; r_r <= 3'd0; dx_r <= 4'd0; dy_r <= 4'd0;
          col_r <= nx_r; row_r <= {2'b0, cmd_r.page, 3'd0};
          st_r <= gi[5] ? S_PIX : S_NEXT;
        end
        S_PIX: begin
          if (pix_on) st_r <= S_RMW_RD;
          else st_r <= S_RMW_WR;
        end
        S_RMW_RD: st_r <= S_RMW_WR;
        S_RMW_WR: begin
          // advance dx, dy, r, c
          st_r <= S_PIX;
          if (dx_r != cmd_r.scale - 4'd1 && set_pix) begin
            dx_r <= dx_r + 4'd1; col_r <= col_r + 8'd1;
          end else if (dy_r != cmd_r.scale - 4'd1 && set_pix) begin
            dx_r <= 4'd0; dy_r <= dy_r + 4'd1;
            col_r <= cx_r + 8'(c_r) * sc8; row_r <= row_r + 8'd1;
          end else begin
            dx_r <= 4'd0; dy_r <= 4'd0;
            if (r_r != 3'd6) begin
              r_r <= r_r + 3'd1;
              col_r <= cx_r + 8'(c_r) * sc8;
              row_r <= {2'b0, cmd_r.page, 3'd0} + 8'(r_r + 3'd1) * sc8;
            end else begin
              r_r <= 3'd0;
              if (c_r == 3'd4) st_r <= S_NEXT;
              else begin
                c_r <= c_r + 3'd1;
                col_r <= cx_r + 8'(c_r + 3'd1) * sc8;
                row_r <= {2'b0, cmd_r.page, 3'd0};
              end
            end
          end
          // no write when pixel was not set or was off screen
        end
        S_NEXT: begin
          nx_r <= nx_r + 8'(6 * 32'(cmd_r.scale));
          if (cmd_r.op == OP_NUM && di_r != 4'd0) begin
            di_r <= di_r - 4'd1; st_r <= S_GLYPH;
          end else st_r <= S_OUT;
        end
        S_RD: begin
          col_r <= cmd_r.x; row_r <= {2'b0, cmd_r.page, 3'd0};
          st_r <= S_RD2;
        end
        S_RD2: begin
          if (cmd_r.x < 8'(WIDTH) && 32'(cmd_r.page) < PAGES) rd_r <= rdata_r;
          st_r <= S_OUT;
        end
        S_OUT: if (!ov_r) begin
          ov_r <= 1'b1; out_rd_r <= rd_r; out_nx_r <= nx_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/scaled_glyph_framebuffer_renderer_core.sv
// ----------------------------------------------------------------------------
// scaled_glyph_framebuffer_renderer_core
// Number commands first split the value into digits by repeated divide-by-ten.
// One command at a time in the back end; the front queue holds two more.
// Reset: synchronous; a clearing pass over the whole store runs before the back end takes a command.
// ----------------------------------------------------------------------------
module scaled_glyph_framebuffer_renderer_core
  import sgfr_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  sgfr_in_if.sink     in_ch,
  sgfr_out_if.source  out_ch
);
  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  cmd_t q_in_data, q_out_data;

  // front end: normalize scale
  sgfr_front u_front (.in_ch(in_ch), .q_valid(q_in_valid), .q_ready(q_in_ready),
                      .q_data(q_in_data));

  // decoupling queue
  sgfr_cmd_fifo u_fifo (.clk, .rst_n, .wr_valid(q_in_valid), .wr_ready(q_in_ready),
                        .wr_data(q_in_data), .rd_valid(q_out_valid),
                        .rd_ready(q_out_ready), .rd_data(q_out_data));

  // back end: store access sequencer
  sgfr_back u_back (.clk, .rst_n, .q_valid(q_out_valid), .q_ready(q_out_ready),
                    .q_data(q_out_data), .out_ch(out_ch));
endmodule
